/* hw/rtl/lzw_pkg.sv */
// Shared types and constants for the hashed variable-width LZW compressor.
package lzw_pkg;

  // Widest code the packer handles; narrower configurations zero-extend.
  localparam int unsigned CODE_W = 15;

  localparam logic [CODE_W-1:0] CODE_GROW  = 15'd256;
  localparam logic [CODE_W-1:0] CODE_END   = 15'd257;
  localparam logic [CODE_W-1:0] CODE_CLEAR = 15'd258;
  localparam logic [CODE_W-1:0] FIRST_FREE = 15'd259;
  localparam logic [3:0]        START_WIDTH = 4'd9;
  localparam logic [4:0]        WORD_BITS   = 5'd16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  // One request to the bit packer: a code at a width, or a final flush.
  typedef struct packed {
    logic              flush;
    logic              final_code;
    logic [3:0]        width;
    logic [CODE_W-1:0] code;
  } pack_cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CMP,
    S_MISS,
    S_GROW,
    S_FIN_PREFIX,
    S_FIN_END,
    S_FIN_FLUSH
  } eng_state_e;

endpackage

/* hw/rtl/lzw_if.sv */
// Valid/ready channel interfaces for input bytes and packed output words.
interface lzw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lzw_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_word;
  logic        last_word;
  modport source (output valid, output out_word, output last_word, input ready);
  modport sink (input valid, input out_word, input last_word, output ready);
endinterface

/* hw/rtl/lzw_front.sv */
// Front end: two-entry queue that takes input byte transfers ahead of the engine.
module lzw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  lzw_byte_if.sink            in_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output lzw_pkg::byte_item_t item_o
);

  lzw_pkg::byte_item_t buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_i.ready   = (count_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = buf_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store payload on each input transfer
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= '{data_byte: in_i.data_byte, last_byte: in_i.last_byte};
    end
  end

endmodule

/* hw/rtl/lzw_engine.sv */
// Back end: hashed string table, probe sequencer and code emission.
module lzw_engine #(
  parameter int unsigned MAX_CODE_BITS = 15,
  parameter int unsigned TABLE_ENTRIES = 35531
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  lzw_pkg::byte_item_t item_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output lzw_pkg::pack_cmd_t  cmd_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned HW    = (MAX_CODE_BITS > IDX_W) ? MAX_CODE_BITS : IDX_W;
  localparam int unsigned NC_W  = MAX_CODE_BITS + 1;
  localparam int unsigned EW    = 1 + 2 * MAX_CODE_BITS + 8;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] N_IDX    = IDX_W'(TABLE_ENTRIES);
  localparam logic [HW-1:0]    N_HASH   = HW'(TABLE_ENTRIES);

  lzw_pkg::eng_state_e state_q, state_d;
  logic [MAX_CODE_BITS-1:0] prefix_q, prefix_d;
  logic                     have_first_q, have_first_d;
  logic [3:0]               width_q, width_d;
  logic [NC_W-1:0]          free_code_q, free_code_d;
  logic [7:0]               ch_q, ch_d;
  logic                     last_q, last_d;
  logic [HW-1:0]            hash_q, hash_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [IDX_W-1:0]         step_q, step_d;
  logic [IDX_W-1:0]         cnt_q, cnt_d;

  logic [EW-1:0]    table_q [TABLE_ENTRIES];
  logic [EW-1:0]    rd_q;
  logic             we, re;
  logic [IDX_W-1:0] waddr;
  logic [EW-1:0]    wdata;

  logic                     ent_valid;
  logic [MAX_CODE_BITS-1:0] ent_code, ent_prefix;
  logic [7:0]               ent_char;
  logic [NC_W-1:0]          nc_inc;
  logic [IDX_W-1:0]         hash_idx;

  assign {ent_valid, ent_code, ent_prefix, ent_char} = rd_q;
  assign nc_inc   = free_code_q + NC_W'(1);
  assign hash_idx = hash_q[IDX_W-1:0];

  // Next state, probe control and packer requests
  always_comb begin
    state_d      = state_q;
    prefix_d     = prefix_q;
    have_first_d = have_first_q;
    width_d      = width_q;
    free_code_d  = free_code_q;
    ch_d         = ch_q;
    last_d       = last_q;
    hash_d       = hash_q;
    idx_d        = idx_q;
    step_d       = step_q;
    cnt_d        = cnt_q;
    item_ready_o = 1'b0;
    cmd_valid_o  = 1'b0;
    cmd_o        = '{flush: 1'b0, final_code: 1'b0, width: width_q,
                     code: lzw_pkg::CODE_W'(prefix_q)};
    we           = 1'b0;
    re           = 1'b0;
    waddr        = idx_q;
    wdata        = {1'b1, free_code_q[MAX_CODE_BITS-1:0], prefix_q, ch_q};

    case (state_q)
      lzw_pkg::S_CLEAR: begin
        // Sweep valid bits, one entry a cycle
        we    = 1'b1;
        waddr = idx_q;
        wdata = '0;
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = last_q ? lzw_pkg::S_FIN_PREFIX : lzw_pkg::S_IDLE;
        end
      end
      lzw_pkg::S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          ch_d   = item_i.data_byte;
          last_d = item_i.last_byte;
          if (!have_first_q) begin
            prefix_d     = MAX_CODE_BITS'(item_i.data_byte);
            have_first_d = 1'b1;
            state_d      = item_i.last_byte ? lzw_pkg::S_FIN_PREFIX : lzw_pkg::S_IDLE;
          end else begin
            hash_d  = (HW'(item_i.data_byte) << (width_q - 4'd8)) ^ HW'(prefix_q);
            state_d = lzw_pkg::S_HASH;
          end
        end
      end
      lzw_pkg::S_HASH: begin
        // Reduce modulo table size by repeated subtraction
        if (hash_q >= N_HASH) begin
          hash_d = hash_q - N_HASH;
        end else begin
          idx_d   = hash_idx;
          step_d  = (hash_idx == '0) ? IDX_W'(1) : N_IDX - hash_idx;
          cnt_d   = '0;
          state_d = lzw_pkg::S_READ;
        end
      end
      lzw_pkg::S_READ: begin
        re      = 1'b1;
        state_d = lzw_pkg::S_CMP;
      end
      lzw_pkg::S_CMP: begin
        if (!ent_valid) begin
          we      = 1'b1;
          state_d = lzw_pkg::S_MISS;
        end else if (ent_prefix == prefix_q && ent_char == ch_q) begin
          prefix_d = ent_code;
          state_d  = last_q ? lzw_pkg::S_FIN_PREFIX : lzw_pkg::S_IDLE;
        end else if (cnt_q == LAST_IDX) begin
          state_d = lzw_pkg::S_MISS;
        end else begin
          cnt_d   = cnt_q + IDX_W'(1);
          idx_d   = (idx_q >= step_q) ? idx_q - step_q : idx_q + (N_IDX - step_q);
          state_d = lzw_pkg::S_READ;
        end
      end
      lzw_pkg::S_MISS: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) begin
          free_code_d = nc_inc;
          prefix_d    = MAX_CODE_BITS'(ch_q);
          if ((nc_inc >> width_q) != '0) begin
            state_d = lzw_pkg::S_GROW;
          end else begin
            state_d = last_q ? lzw_pkg::S_FIN_PREFIX : lzw_pkg::S_IDLE;
          end
        end
      end
      lzw_pkg::S_GROW: begin
        cmd_valid_o = 1'b1;
        cmd_o.code  = free_code_q[MAX_CODE_BITS] ? lzw_pkg::CODE_CLEAR : lzw_pkg::CODE_GROW;
        if (cmd_ready_i) begin
          if (free_code_q[MAX_CODE_BITS]) begin
            width_d     = lzw_pkg::START_WIDTH;
            free_code_d = NC_W'(lzw_pkg::FIRST_FREE);
            idx_d       = '0;
            state_d     = lzw_pkg::S_CLEAR;
          end else begin
            width_d = width_q + 4'd1;
            state_d = last_q ? lzw_pkg::S_FIN_PREFIX : lzw_pkg::S_IDLE;
          end
        end
      end
      lzw_pkg::S_FIN_PREFIX: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) begin
          state_d = lzw_pkg::S_FIN_END;
        end
      end
      lzw_pkg::S_FIN_END: begin
        cmd_valid_o      = 1'b1;
        cmd_o.code       = lzw_pkg::CODE_END;
        cmd_o.final_code = 1'b1;
        if (cmd_ready_i) begin
          state_d = lzw_pkg::S_FIN_FLUSH;
        end
      end
      lzw_pkg::S_FIN_FLUSH: begin
        cmd_valid_o = 1'b1;
        cmd_o.flush = 1'b1;
        if (cmd_ready_i) begin
          // Return the whole block to its reset state
          prefix_d     = '0;
          have_first_d = 1'b0;
          width_d      = lzw_pkg::START_WIDTH;
          free_code_d  = NC_W'(lzw_pkg::FIRST_FREE);
          last_d       = 1'b0;
          idx_d        = '0;
          state_d      = lzw_pkg::S_CLEAR;
        end
      end
      default: begin
        state_d = lzw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lzw_pkg::S_CLEAR;
      prefix_q     <= '0;
      have_first_q <= 1'b0;
      width_q      <= lzw_pkg::START_WIDTH;
      free_code_q  <= NC_W'(lzw_pkg::FIRST_FREE);
      last_q       <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      prefix_q     <= prefix_d;
      have_first_q <= have_first_d;
      width_q      <= width_d;
      free_code_q  <= free_code_d;
      last_q       <= last_d;
      idx_q        <= idx_d;
    end
  end

  // Probe datapath registers
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    hash_q <= hash_d;
    step_q <= step_d;
    cnt_q  <= cnt_d;
  end

  // String table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      table_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= table_q[idx_q];
    end
  end

endmodule

/* hw/rtl/lzw_packer.sv */
// Bit packer: places codes MSB first into 16-bit words behind an output register.
module lzw_packer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  lzw_pkg::pack_cmd_t cmd_i,
  lzw_word_if.source         out_o
);

  logic [15:0] pack_q, pack_d;
  logic [4:0]  free_q, free_d;
  logic        ov_q;
  logic [15:0] word_q, word_d;
  logic        wlast_q, wlast_d;
  logic        emit;
  logic        take;
  logic [4:0]  w5, rest;
  logic [14:0] code_m;

  assign out_o.valid     = ov_q;
  assign out_o.out_word  = word_q;
  assign out_o.last_word = wlast_q;
  assign cmd_ready_o     = !ov_q || out_o.ready;
  assign take            = cmd_valid_i && cmd_ready_o;
  assign w5              = {1'b0, cmd_i.width};
  assign rest            = w5 - free_q;
  assign code_m          = cmd_i.code & 15'((32'd1 << cmd_i.width) - 32'd1);

  // Fill the current word, spill into the next
  always_comb begin
    pack_d  = pack_q;
    free_d  = free_q;
    word_d  = word_q;
    wlast_d = 1'b0;
    emit    = 1'b0;
    if (cmd_i.flush) begin
      if (free_q != lzw_pkg::WORD_BITS) begin
        emit    = 1'b1;
        word_d  = 16'(32'(pack_q) << free_q);
        wlast_d = 1'b1;
        pack_d  = '0;
        free_d  = lzw_pkg::WORD_BITS;
      end
    end else if (free_q >= w5) begin
      pack_d = 16'((32'(pack_q) << cmd_i.width) | 32'(code_m));
      if (free_q == w5) begin
        emit    = 1'b1;
        word_d  = pack_d;
        wlast_d = cmd_i.final_code;
        pack_d  = '0;
        free_d  = lzw_pkg::WORD_BITS;
      end else begin
        free_d = free_q - w5;
      end
    end else begin
      emit   = 1'b1;
      word_d = 16'((32'(pack_q) << free_q) | 32'(code_m >> rest));
      pack_d = 16'(code_m & 15'((32'd1 << rest) - 32'd1));
      free_d = lzw_pkg::WORD_BITS - rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q  <= '0;
      free_q  <= lzw_pkg::WORD_BITS;
      ov_q    <= 1'b0;
      wlast_q <= 1'b0;
    end else begin
      if (take) begin
        pack_q <= pack_d;
        free_q <= free_d;
      end
      if (take && emit) begin
        ov_q    <= 1'b1;
        wlast_q <= wlast_d;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Hold the word until its transfer
  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      word_q <= word_d;
    end
  end

endmodule

/* hw/rtl/lzw_compress_hashed_variable_width_core.sv */
// Hashed LZW compressor: bytes are taken one at a time and hashed with the prefix; the hash
// is reduced by subtraction of TABLE_ENTRIES and probed in the string table (one write port,
// one registered read port); a miss emits the prefix code, then a grow or clear code on a width change.
// Output words leave through a one-word register; the input queue holds two bytes.
// After reset, after a reset code and after the last byte, the table is swept entry by
// entry while no byte is taken; reset is asynchronous, active low.
module lzw_compress_hashed_variable_width_core #(
  parameter int unsigned MAX_CODE_BITS = 15,
  parameter int unsigned TABLE_ENTRIES = 35531
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lzw_byte_if.sink   in_i,
  lzw_word_if.source out_o
);

  logic                item_valid, item_ready;
  lzw_pkg::byte_item_t item;
  logic                cmd_valid, cmd_ready;
  lzw_pkg::pack_cmd_t  cmd;

  lzw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  lzw_engine #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  lzw_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_o       (out_o)
  );

  // Code widths stay within the configured range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && !cmd.flush) |-> (cmd.width >= 4'd9 && cmd.width <= 4'(MAX_CODE_BITS)))
    else $error("code width out of range");

  // Every emitted code fits its width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && !cmd.flush) |-> ((32'(cmd.code) >> cmd.width) == 32'd0))
    else $error("code wider than its width");

  // A flush follows the end code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready && cmd.final_code) |=> (cmd_valid && cmd.flush))
    else $error("end code not followed by flush");

endmodule
